[hdl/hrs_pkg.sv]
// hrs_pkg: shared constants, function codes and the popcount tree
// for the hamming range search block; depends on nothing
`default_nettype none

package hrs_pkg;

    localparam int CODE_W       = 64;
    localparam int DIST_W       = 7;
    localparam int INDEX_W      = 6;
    localparam int FUNC_W       = 2;
    localparam int POP_W        = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // balanced adder tree, six levels
    function automatic logic [POP_W-1:0] popcount(input logic [CODE_W-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

`default_nettype wire

[hdl/hrs_ram.sv]
// hrs_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module hrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/hamming_range_search.sv]
// hamming_range_search: top level, code table in one ram, scan pipeline and
// result sequencing; depends on hrs_pkg and hrs_ram
//
//   channel   direction  handshake               beat contents
//   command   in         start & !busy           func, code, dist_limit
//   result    out        strobe (one cycle)      match_index, found, last
//
// clear and append leave busy low
// a query holds busy until its scan pipeline has drained:
// one ram read per stored code, then a popcount stage and a compare stage
// results come out at most one per cycle while the scan runs; the final beat
// follows the drain of the pipeline, so the last hit is held back one stage
// rst_n is asynchronous; it empties the table and aborts any scan
// the receiver cannot stall: every strobe is a delivered beat
`default_nettype none

module hamming_range_search #(
    parameter int CAPACITY = hrs_pkg::CAPACITY_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [hrs_pkg::FUNC_W-1:0]   func,
    input  wire logic [hrs_pkg::CODE_W-1:0]   code,
    input  wire logic [hrs_pkg::DIST_W-1:0]   dist_limit,
    output logic                              strobe,
    output logic      [hrs_pkg::INDEX_W-1:0]  match_index,
    output logic                              found,
    output logic                              last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // control state
    logic                           state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               rd_addr_reg, rd_addr_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s2_valid_reg, s2_valid_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic                           strobe_reg, strobe_next;

    // payload
    logic [hrs_pkg::CODE_W-1:0]     qcode_reg, qcode_next;
    logic [hrs_pkg::DIST_W-1:0]     maxd_reg, maxd_next;
    logic [IDX_W-1:0]               s1_idx_reg, s1_idx_next;
    logic [IDX_W-1:0]               s2_idx_reg, s2_idx_next;
    logic [hrs_pkg::POP_W-1:0]      pop_reg, pop_next;
    logic [IDX_W-1:0]               pend_idx_reg, pend_idx_next;
    logic [hrs_pkg::INDEX_W-1:0]    index_reg, index_next;
    logic                           found_reg, found_next;
    logic                           last_reg, last_next;

    // ram side
    logic                           ram_we;
    logic [IDX_W-1:0]               ram_raddr;
    logic [hrs_pkg::CODE_W-1:0]     ram_rdata;

    logic                           accept;
    logic                           issue;
    logic                           hit;
    logic                           drained;

    assign accept = start && (state_reg == S_IDLE);
    // appends beyond capacity are dropped
    assign ram_we = accept && (func == hrs_pkg::FUNC_APPEND) && (count_reg < CAP_CNT);
    assign ram_raddr = rd_addr_reg[IDX_W-1:0];

    hrs_ram #(
        .WIDTH (hrs_pkg::CODE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan pipeline: read issue, popcount, compare
    assign issue   = (state_reg == S_SCAN) && (rd_addr_reg < count_reg);
    assign hit     = s2_valid_reg && (pop_reg <= maxd_reg);
    assign drained = (state_reg == S_SCAN) && !issue && !s1_valid_reg && !s2_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_addr_next    = rd_addr_reg;
        qcode_next      = qcode_reg;
        maxd_next       = maxd_reg;
        s1_valid_next   = issue;
        s1_idx_next     = rd_addr_reg[IDX_W-1:0];
        s2_valid_next   = s1_valid_reg;
        s2_idx_next     = s1_idx_reg;
        pop_next        = hrs_pkg::popcount(ram_rdata ^ qcode_reg);
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        strobe_next     = 1'b0;
        index_next      = hrs_pkg::INDEX_W'(pend_idx_reg);
        found_next      = 1'b1;
        last_next       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        hrs_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        hrs_pkg::FUNC_APPEND:
                        begin
                            if (count_reg < CAP_CNT)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        hrs_pkg::FUNC_QUERY:
                        begin
                            state_next      = S_SCAN;
                            qcode_next      = code;
                            maxd_next       = dist_limit;
                            rd_addr_next    = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                end
                // a new hit releases the one held before it, which is not last
                if (hit)
                begin
                    strobe_next     = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = s2_idx_reg;
                end
                if (drained)
                begin
                    state_next      = S_IDLE;
                    strobe_next     = 1'b1;
                    last_next       = 1'b1;
                    found_next      = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        index_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_addr_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_addr_reg    <= rd_addr_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qcode_reg    <= qcode_next;
        maxd_reg     <= maxd_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        pop_reg      <= pop_next;
        pend_idx_reg <= pend_idx_next;
        index_reg    <= index_next;
        found_reg    <= found_next;
        last_reg     <= last_next;
    end

    assign busy        = (state_reg == S_SCAN);
    assign strobe      = strobe_reg;
    assign match_index = index_reg;
    assign found       = found_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // the final beat of a query frees the command side
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("final beat while still scanning");

    // an empty answer is always the only and final beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !found) |-> last)
        else $error("empty answer not marked last");

    // the table never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count beyond capacity");

    // a scan starts with no beat in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !strobe)
        else $error("beat at start of scan");

    // the read pointer never runs past the stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rd_addr_reg <= count_reg))
        else $error("scan read beyond table");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for the hamming range search block, a directed table
// followed by random fill-and-query sessions; depends on hrs_pkg and the rtl top

module tb;

    localparam int HALF_PERIOD   = 6;
    localparam int TOTAL_ITEMS   = 310;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 400;
    localparam int REPORT_CAP    = 40;
    localparam int LIMIT_NS      = 8_000_000;

    // the fourth function code is unused by the block and must be ignored
    localparam logic [hrs_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // one result beat as the block presents it
    typedef struct packed {
        logic [hrs_pkg::INDEX_W-1:0] slot;
        logic                        found;
        logic                        last;
    } hit_t;

    // one row of the directed table; pinned rows carry their answer inline
    typedef struct packed {
        logic [hrs_pkg::FUNC_W-1:0] op;
        logic [hrs_pkg::CODE_W-1:0] word;
        logic [hrs_pkg::DIST_W-1:0] radius;
        logic                       pinned;
        hit_t                       answer;
    } row_t;

    localparam hit_t EMPTY_ANSWER = '{slot: '0, found: 1'b0, last: 1'b1};

    // directed part: empty table, extremes of code and distance, the spare
    // function, a miss on a populated table, clear and refill from slot zero
    localparam row_t DIRECTED [22] = '{
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd0,   1'b1, EMPTY_ANSWER},
        '{hrs_pkg::FUNC_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, EMPTY_ANSWER},
        '{FUNC_SPARE,           64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, '0},
        '{hrs_pkg::FUNC_APPEND, 64'h0000_0000_0000_0000, 7'd0,   1'b0, '0},
        '{hrs_pkg::FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, '0},
        '{hrs_pkg::FUNC_APPEND, 64'h5555_5555_5555_5555, 7'd64,  1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd0,   1'b1, '{6'd0, 1'b1, 1'b1}},
        '{hrs_pkg::FUNC_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   1'b1, '{6'd1, 1'b1, 1'b1}},
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd64,  1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd127, 1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd32,  1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 7'd31,  1'b1, EMPTY_ANSWER},
        '{FUNC_SPARE,           64'h0000_0000_0000_0000, 7'd0,   1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h0F0F_0F0F_0F0F_0F0F, 7'd32,  1'b0, '0},
        '{hrs_pkg::FUNC_APPEND, 64'h8000_0000_0000_0001, 7'd1,   1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h8000_0000_0000_0001, 7'd0,   1'b1, '{6'd3, 1'b1, 1'b1}},
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd2,   1'b0, '0},
        '{hrs_pkg::FUNC_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h0000_0000_0000_0000, 7'd127, 1'b1, EMPTY_ANSWER},
        '{hrs_pkg::FUNC_APPEND, 64'h7FFF_FFFF_FFFF_FFFE, 7'd63,  1'b0, '0},
        '{hrs_pkg::FUNC_QUERY,  64'h7FFF_FFFF_FFFF_FFFE, 7'd0,   1'b1, '{6'd0, 1'b1, 1'b1}},
        '{hrs_pkg::FUNC_CLEAR,  64'h0000_0000_0000_0000, 7'd0,   1'b0, '0}
    };

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          start      = 1'b0;
    logic [hrs_pkg::FUNC_W-1:0]    func       = hrs_pkg::FUNC_CLEAR;
    logic [hrs_pkg::CODE_W-1:0]    code       = '0;
    logic [hrs_pkg::DIST_W-1:0]    dist_limit = '0;
    logic                          busy;
    logic                          strobe;
    logic [hrs_pkg::INDEX_W-1:0]   match_index;
    logic                          found;
    logic                          last;

    // predictor copy of the block state
    logic [hrs_pkg::CODE_W-1:0]    stored_codes [hrs_pkg::CAPACITY_DEF];
    int                            stored_len = 0;

    // result beats still owed by the block, oldest first
    hit_t                expected_hits [$];
    hit_t                due;

    int                  error_count      = 0;
    int                  effective_cmds   = 0;
    int                  ignored_cmds     = 0;
    int                  queries_sent     = 0;
    int                  hit_beats        = 0;
    int                  empty_beats      = 0;
    int                  quiet_run        = 0;

    always #HALF_PERIOD clk = ~clk;

    hamming_range_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .code         (code),
        .dist_limit   (dist_limit),
        .strobe       (strobe),
        .match_index  (match_index),
        .found        (found),
        .last         (last)
    );

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("tb: mismatch at %0t ns: %s", $time, what);
    endtask

    // predictor: update the table and queue the beats one command causes;
    // returns 0 when the block is expected to ignore the command
    function automatic bit apply_command(input logic [hrs_pkg::FUNC_W-1:0] f,
                                         input logic [hrs_pkg::CODE_W-1:0] c,
                                         input logic [hrs_pkg::DIST_W-1:0] d,
                                         input bit pinned,
                                         input hit_t pin);
        hit_t held;
        bit   have_held;
        bit   took;
        have_held = 1'b0;
        took      = 1'b1;
        case (f)
            hrs_pkg::FUNC_CLEAR:
            begin
                // stored codes stay put, only the fill level drops
                stored_len = 0;
            end
            hrs_pkg::FUNC_APPEND:
            begin
                if (stored_len < hrs_pkg::CAPACITY_DEF)
                begin
                    stored_codes[stored_len] = c;
                    stored_len++;
                end
                else
                begin
                    took = 1'b0;
                end
            end
            hrs_pkg::FUNC_QUERY:
            begin
                queries_sent++;
                if (pinned)
                begin
                    expected_hits = {expected_hits, pin};
                end
                else
                begin
                    // hold each hit back one step so the final one gets last
                    for (int i = 0; i < stored_len; i++)
                    begin
                        if ($countones(c ^ stored_codes[i]) <= d)
                        begin
                            if (have_held)
                                expected_hits = {expected_hits, held};
                            held.slot  = hrs_pkg::INDEX_W'(i);
                            held.found = 1'b1;
                            held.last  = 1'b0;
                            have_held  = 1'b1;
                        end
                    end
                    if (have_held)
                    begin
                        held.last = 1'b1;
                        expected_hits = {expected_hits, held};
                    end
                    else
                    begin
                        expected_hits = {expected_hits, EMPTY_ANSWER};
                    end
                end
            end
            default:
            begin
                took = 1'b0;
            end
        endcase
        return took;
    endfunction

    // present one command beat, wait for the handshake, then predict;
    // called right after a rising edge, start is touched once per step
    task automatic issue_command(input logic [hrs_pkg::FUNC_W-1:0] f,
                                 input logic [hrs_pkg::CODE_W-1:0] c,
                                 input logic [hrs_pkg::DIST_W-1:0] d,
                                 input bit pinned,
                                 input hit_t pin);
        int gap;
        if (quiet_run > 0)
        begin
            gap = 0;
            quiet_run--;
        end
        else
        begin
            gap = $urandom_range(0, 11);
            // now and then a stretch of back-to-back beats
            if ($urandom_range(0, 15) == 0)
                quiet_run = $urandom_range(5, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        code       <= c;
        dist_limit <= d;
        // busy read here is the value the block showed at this edge
        do
            @(posedge clk);
        while (busy);
        if (apply_command(f, c, d, pinned, pin))
            effective_cmds++;
        else
            ignored_cmds++;
    endtask

    function automatic logic [hrs_pkg::CODE_W-1:0] rand_code();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [hrs_pkg::DIST_W-1:0] rand_radius();
        return hrs_pkg::DIST_W'($urandom_range(0, 127));
    endfunction

    // a code a few bit flips away from the anchor, so small radii still hit
    function automatic logic [hrs_pkg::CODE_W-1:0] near_code(
        input logic [hrs_pkg::CODE_W-1:0] anchor);
        logic [hrs_pkg::CODE_W-1:0] v;
        int                         flips;
        int                         b;
        v     = anchor;
        flips = $urandom_range(0, 6);
        for (int k = 0; k < flips; k++)
        begin
            b    = $urandom_range(0, hrs_pkg::CODE_W - 1);
            v[b] = ~v[b];
        end
        return v;
    endfunction

    // occasional spare function beat with random fields
    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0)
            issue_command(FUNC_SPARE, rand_code(), rand_radius(), 1'b0, '0);
    endtask

    // one session: mostly a clear, a fill around a random anchor, then queries;
    // an overfill session fills the table to capacity or past it
    task automatic run_session(input bit overfill);
        logic [hrs_pkg::CODE_W-1:0] anchor;
        logic [hrs_pkg::CODE_W-1:0] probe;
        logic [hrs_pkg::DIST_W-1:0] radius;
        int                         n_fill;
        int                         n_ask;
        anchor = rand_code();
        // skipping the clear lets the table keep growing across sessions
        if (overfill || $urandom_range(0, 4) != 0)
            issue_command(hrs_pkg::FUNC_CLEAR, rand_code(), rand_radius(), 1'b0, '0);
        n_fill = overfill ? $urandom_range(hrs_pkg::CAPACITY_DEF, hrs_pkg::CAPACITY_DEF + 4)
                          : $urandom_range(1, 12);
        for (int k = 0; k < n_fill; k++)
        begin
            maybe_noise();
            if ($urandom_range(0, 3) == 0)
                issue_command(hrs_pkg::FUNC_APPEND, rand_code(), rand_radius(), 1'b0, '0);
            else
                issue_command(hrs_pkg::FUNC_APPEND, near_code(anchor), rand_radius(),
                              1'b0, '0);
        end
        n_ask = $urandom_range(2, 5);
        for (int k = 0; k < n_ask; k++)
        begin
            maybe_noise();
            probe  = ($urandom_range(0, 4) == 0) ? rand_code() : near_code(anchor);
            radius = ($urandom_range(0, 5) == 0) ? rand_radius()
                                                 : hrs_pkg::DIST_W'($urandom_range(0, 12));
            issue_command(hrs_pkg::FUNC_QUERY, probe, radius, 1'b0, '0);
        end
    endtask

    // result side: every strobe is a delivered beat, checked field by field
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (found)
                hit_beats++;
            else
                empty_beats++;
            if (expected_hits.size() == 0)
            begin
                report_mismatch($sformatf("stray beat slot=%0d found=%0b last=%0b",
                                          match_index, found, last));
            end
            else
            begin
                due = expected_hits.pop_front();
                if (match_index !== due.slot)
                    report_mismatch($sformatf("match_index %0d, wanted %0d",
                                              match_index, due.slot));
                if (found !== due.found)
                    report_mismatch($sformatf("found %0b, wanted %0b", found, due.found));
                if (last !== due.last)
                    report_mismatch($sformatf("last %0b, wanted %0b", last, due.last));
            end
        end
    end

    initial
    begin
        int  waited;
        bit  first;
        waited = 0;
        first  = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < $size(DIRECTED); r++)
            issue_command(DIRECTED[r].op, DIRECTED[r].word, DIRECTED[r].radius,
                          DIRECTED[r].pinned, DIRECTED[r].answer);

        // random sessions; the first one always fills the table to capacity or past it
        while (effective_cmds + ignored_cmds < TOTAL_ITEMS)
        begin
            run_session(first);
            first = 1'b0;
        end
        start <= 1'b0;

        // drain: wait for owed beats, bounded
        while (expected_hits.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_hits.size() != 0)
        begin
            $display("tb: %0d result beats never arrived", expected_hits.size());
            $display("tb: done, errors");
        end
        else
        begin
            // catch any stray beat after the last query
            repeat (SETTLE_CYCLES) @(posedge clk);
            $display("tb: %0d queries, %0d match beats, %0d empty answers",
                     queries_sent, hit_beats, empty_beats);
            $display("tb: %0d commands ignored (spare function, appends to a full table)",
                     ignored_cmds);
            if (error_count == 0)
                $display("tb: done, clean");
            else
                $display("tb: done, errors");
        end
        $finish;
    end

    // hard stop if a handshake or the drain never completes
    initial
    begin
        #(LIMIT_NS);
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/hrs_pkg.sv
hdl/hrs_ram.sv
hdl/hamming_range_search.sv
verif/tb.sv
